// ===== rtl/dvru_pkg.sv =====
// ----------------------------------------------------------------------------
// dvru_pkg
// Shared widths, codes and beat types of the distance-vector route update unit.
// ----------------------------------------------------------------------------
package dvru_pkg;

  localparam int unsigned ROUTER_W        = 7;
  localparam int unsigned COST_W          = 17;
  localparam int unsigned ADV_W           = 16;
  localparam int unsigned MAX_ROUTERS_DEF = 64;

  localparam logic [ROUTER_W-1:0] SELF_ROUTER_RST  = ROUTER_W'(1);
  localparam logic [ROUTER_W-1:0] ROUTER_COUNT_RST = ROUTER_W'(64);
  localparam logic [COST_W-1:0]   INFINITY_RST     = COST_W'(100000);

  // Item kinds
  localparam logic KIND_CLEAR = 1'b0;
  localparam logic KIND_RELAX = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SELF_ROUTER   = 2'd0,
    CFG_ROUTER_COUNT  = 2'd1,
    CFG_INFINITY_COST = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic                kind;
    logic [ROUTER_W-1:0] destination;
    logic [ROUTER_W-1:0] neighbour_id;
    logic [ADV_W-1:0]    advertised_cost;
    logic [ADV_W-1:0]    link_delay;
  } in_t;

  typedef struct packed {
    logic [ROUTER_W-1:0] entry_destination;
    logic [COST_W-1:0]   best_cost;
    logic [ROUTER_W-1:0] next_hop;
    logic                changed;
    logic                bad_destination;
  } result_t;

endpackage

// ===== rtl/dvru_ram.sv =====
// ----------------------------------------------------------------------------
// dvru_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dvru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/distance_vector_route_update_unit.sv =====
// ----------------------------------------------------------------------------
// distance_vector_route_update_unit
// Routing table of best cost and next hop per destination, updated by
// Bellman-Ford relaxation. Each accepted item has a read step, which reads
// the table entry from the single table RAM (registered read), then a compute
// step, which compares, writes back and registers the result; busy is high
// during the compute step, so no new item is taken until it is computed.
// Every item yields exactly one result beat, shown on result_o for one cycle
// with done_o high, set by the compute step; the receiver cannot stall
// it. A clear item drops all entries to invalid at once through per-entry
// valid flops, so there is no clearing pass after reset or after a clear.
// Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module distance_vector_route_update_unit #(
  parameter int unsigned MAX_ROUTERS = dvru_pkg::MAX_ROUTERS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command channel
  input  logic                            start,
  output logic                            busy,
  input  dvru_pkg::in_t                   in_i,
  // result channel
  output logic                            done_o,
  output dvru_pkg::result_t               result_o,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [dvru_pkg::COST_W-1:0]     cfg_wdata_i
);

  import dvru_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_ROUTERS);
  localparam int unsigned ENT_W  = COST_W + ROUTER_W;

  // configuration
  logic [ROUTER_W-1:0] self_q;
  logic [ROUTER_W-1:0] count_q;
  logic [COST_W-1:0]   inf_q;

  // control
  logic                   busy_q;
  logic                   done_q;
  logic [MAX_ROUTERS-1:0] valid_q;
  logic                   accept;

  // stage registers of the item in flight (payload, no reset)
  logic                kind_q;
  logic [ROUTER_W-1:0] dest_q;
  logic [ROUTER_W-1:0] nbr_q;
  logic [COST_W-1:0]   sum_q;
  logic                bad_q;
  logic                own_q;
  logic [IDX_W-1:0]    idx_q;
  result_t             result_q;

  // accept-side decode
  logic [ROUTER_W-1:0] dest_m1;
  logic [IDX_W-1:0]    rd_idx;
  logic                bad_d;

  // compute side
  logic [ENT_W-1:0]    ram_rdata;
  logic [ENT_W-1:0]    ram_wdata;
  logic                ram_we;
  logic [COST_W-1:0]   cur_cost;
  logic [ROUTER_W-1:0] cur_hop;
  result_t             result_d;

  assign accept  = start && !busy_q;
  assign dest_m1 = in_i.destination - ROUTER_W'(1);
  assign rd_idx  = dest_m1[IDX_W-1:0];
  assign bad_d   = (in_i.destination == '0) ||
                   (in_i.destination > count_q) ||
                   (in_i.destination > ROUTER_W'(MAX_ROUTERS));

  // Cost and hop of each destination live together in one RAM word.
  dvru_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_ROUTERS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  // Invalid entries read as infinity with no next hop.
  assign cur_cost  = valid_q[idx_q] ? ram_rdata[ENT_W-1 -: COST_W] : inf_q;
  assign cur_hop   = valid_q[idx_q] ? ram_rdata[ROUTER_W-1:0] : '0;
  assign ram_wdata = {sum_q, nbr_q};

  // Relax: replace only on a strictly smaller offer, so the first one wins ties.
  always_comb begin
    result_d = '0;
    ram_we   = 1'b0;
    if (busy_q && (kind_q == KIND_RELAX)) begin
      result_d.entry_destination = dest_q;
      if (bad_q) begin
        result_d.bad_destination = 1'b1;
      end else if (!own_q) begin
        if (sum_q < cur_cost) begin
          ram_we             = 1'b1;
          result_d.best_cost = sum_q;
          result_d.next_hop  = nbr_q;
          result_d.changed   = 1'b1;
        end else begin
          result_d.best_cost = cur_cost;
          result_d.next_hop  = cur_hop;
        end
      end
    end
  end

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q  <= SELF_ROUTER_RST;
      count_q <= ROUTER_COUNT_RST;
      inf_q   <= INFINITY_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SELF_ROUTER:   self_q  <= cfg_wdata_i[ROUTER_W-1:0];
        CFG_ROUTER_COUNT:  count_q <= cfg_wdata_i[ROUTER_W-1:0];
        CFG_INFINITY_COST: inf_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Control: busy covers the compute cycle, done marks the result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      valid_q <= '0;
    end else begin
      busy_q <= accept;
      done_q <= busy_q;
      if (accept && (in_i.kind == KIND_CLEAR)) begin
        valid_q <= '0;
      end else if (ram_we) begin
        valid_q[idx_q] <= 1'b1;
      end
    end
  end

  // Capture the item on accept, the result at the end of the compute cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_i.kind;
      dest_q <= in_i.destination;
      nbr_q  <= in_i.neighbour_id;
      sum_q  <= COST_W'(in_i.advertised_cost) + COST_W'(in_i.link_delay);
      bad_q  <= bad_d;
      own_q  <= (in_i.destination == self_q);
      idx_q  <= rd_idx;
    end
    if (busy_q) begin
      result_q <= result_d;
    end
  end

  assign busy     = busy_q;
  assign done_o   = done_q;
  assign result_o = result_q;

  // Every accepted item yields its result beat after the compute step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("accepted item produced no result beat");

  // The table is only written in the compute cycle of a valid relax item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (busy_q && (kind_q == KIND_RELAX) && !bad_q && !own_q))
    else $error("table written outside a relax compute cycle");

  // A rejected destination never reports an update.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.bad_destination) |->
      (!result_o.changed && (result_o.best_cost == '0) && (result_o.next_hop == '0)))
    else $error("bad destination reported a route");

  // No new item while the previous one is still computing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> !busy_q)
    else $error("busy held longer than one compute cycle");

endmodule

// ===== sim/tb_distance_vector_route_update_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_distance_vector_route_update_unit
// Self-checking bench for the route update unit: a directed table of edge
// cases, then random relax/clear traffic over several table settings; each
// result beat is checked field by field against its row or an in-bench routing table.
// ----------------------------------------------------------------------------
module tb_distance_vector_route_update_unit;

  import dvru_pkg::*;

  localparam int unsigned TABLE_DEPTH    = MAX_ROUTERS_DEF;
  localparam int unsigned SLOT_W         = $clog2(TABLE_DEPTH);
  localparam int unsigned PHASES         = 8;
  localparam int unsigned BEATS_PER_PASS = 200;
  localparam int unsigned DRAIN_LIMIT    = 500;

  typedef struct {
    in_t     beat;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  in_t     in_i;
  logic    done_o;
  result_t result_o;
  logic    cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [COST_W-1:0] cfg_wdata_i;

  // Mirror of the routing table and its registers
  logic [COST_W-1:0]   cost_mem  [TABLE_DEPTH];
  logic [ROUTER_W-1:0] hop_mem   [TABLE_DEPTH];
  bit                  valid_mem [TABLE_DEPTH];
  logic [ROUTER_W-1:0] cfg_self;
  logic [ROUTER_W-1:0] cfg_count;
  logic [COST_W-1:0]   cfg_inf;

  result_t  expected_entries_q[$];
  dir_row_t dir_rows[$];

  int unsigned mismatch_count;
  int unsigned beats_sent;
  int unsigned clears_sent;
  int unsigned results_seen;
  int unsigned improvements_seen;
  int unsigned bad_dest_seen;

  distance_vector_route_update_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout: %0d results still pending", expected_entries_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Apply one beat to the mirrored table and return the entry it reports.
  function automatic result_t relax_route(in_t beat);
    result_t             rep;
    logic [COST_W-1:0]   sum;
    logic [COST_W-1:0]   cur_cost;
    logic [ROUTER_W-1:0] cur_hop;
    logic [SLOT_W-1:0]   slot;
    rep = '0;
    if (beat.kind == KIND_CLEAR) begin
      foreach (valid_mem[k]) valid_mem[k] = 1'b0;
    end else begin
      rep.entry_destination = beat.destination;
      if (beat.destination == '0 || beat.destination > cfg_count ||
          beat.destination > TABLE_DEPTH) begin
        rep.bad_destination = 1'b1;
      end else if (beat.destination != cfg_self) begin
        slot     = SLOT_W'(beat.destination - ROUTER_W'(1));
        cur_cost = valid_mem[slot] ? cost_mem[slot] : cfg_inf;
        cur_hop  = valid_mem[slot] ? hop_mem[slot] : '0;
        sum      = COST_W'(beat.advertised_cost) + COST_W'(beat.link_delay);
        // Strictly less: the earliest offer keeps a tie
        if (sum < cur_cost) begin
          cost_mem[slot]  = sum;
          hop_mem[slot]   = beat.neighbour_id;
          valid_mem[slot] = 1'b1;
          cur_cost        = sum;
          cur_hop         = beat.neighbour_id;
          rep.changed     = 1'b1;
        end
        rep.best_cost = cur_cost;
        rep.next_hop  = cur_hop;
      end
    end
    return rep;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void add_row(in_t beat, bit typed, result_t want);
    dir_row_t row;
    row.beat  = beat;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // Offer one beat (called at a falling edge), hold it until the unit takes it,
  // record what it must report, then idle for a random gap unless told not to.
  task automatic drive_item(in_t beat, bit typed, result_t want, bit no_gaps);
    result_t     predicted;
    int unsigned roll;
    int unsigned gap;
    start <= 1'b1;
    in_i  <= beat;
    do @(posedge clk_i); while (busy);
    predicted = relax_route(beat);
    expected_entries_q.push_back(typed ? want : predicted);
    beats_sent++;
    if (beat.kind == KIND_CLEAR) clears_sent++;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(5, 30);
    @(negedge clk_i);
    if (gap != 0) begin
      // Drop start and park junk on the bus; the unit must ignore it
      start <= 1'b0;
      in_i  <= in_t'({$urandom(), $urandom()});
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Drop start and wait until every pending result has come back or the drain
  // guard runs out, then add a margin. Called at a falling edge.
  task automatic settle_idle();
    int unsigned guard;
    guard = 0;
    start <= 1'b0;
    while (expected_entries_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write one register (called at a falling edge, returns at the next one).
  task automatic write_cfg(cfg_index_e idx, logic [COST_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    case (idx)
      CFG_SELF_ROUTER:   cfg_self  = value[ROUTER_W-1:0];
      CFG_ROUTER_COUNT:  cfg_count = value[ROUTER_W-1:0];
      CFG_INFINITY_COST: cfg_inf   = value;
      default: ;
    endcase
  endtask

  // Result monitor: each strobed beat pops the oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (result_o.changed) improvements_seen++;
      if (result_o.bad_destination) bad_dest_seen++;
      if (expected_entries_q.size() == 0) begin
        $display("%0t: result beat with nothing pending, actual dest %0d cost %0d hop %0d",
                 $time, result_o.entry_destination, result_o.best_cost, result_o.next_hop);
        mismatch_count++;
      end else begin
        want = expected_entries_q.pop_front();
        check_field("entry_destination", want.entry_destination,
                    result_o.entry_destination);
        check_field("best_cost", want.best_cost, result_o.best_cost);
        check_field("next_hop", want.next_hop, result_o.next_hop);
        check_field("changed", want.changed, result_o.changed);
        check_field("bad_destination", want.bad_destination, result_o.bad_destination);
      end
    end
  end

  initial begin
    in_t         beat;
    int unsigned pick;
    int unsigned hi;
    int unsigned span;
    logic [ROUTER_W-1:0] plan_self  [PHASES];
    logic [ROUTER_W-1:0] plan_count [PHASES];
    logic [COST_W-1:0]   plan_inf   [PHASES];

    // Drive every input to a known value from time zero
    start       = 1'b0;
    in_i        = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_SELF_ROUTER;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    mismatch_count    = 0;
    beats_sent        = 0;
    clears_sent       = 0;
    results_seen      = 0;
    improvements_seen = 0;
    bad_dest_seen     = 0;
    cfg_self  = SELF_ROUTER_RST;
    cfg_count = ROUTER_COUNT_RST;
    cfg_inf   = INFINITY_RST;
    foreach (valid_mem[k]) valid_mem[k] = 1'b0;

    // Directed table, run under reset settings: self 1, count 64, infinity 100000.
    // Fields: kind, destination, neighbour, advertised cost, link delay.
    // Clear ignores every other field and reports all zeros
    add_row({KIND_CLEAR, 7'd127, 7'd127, 16'hFFFF, 16'hFFFF}, 1,
            {7'd0, 17'd0, 7'd0, 1'b0, 1'b0});
    // Out-of-range destinations: zero, just above the table, all ones
    add_row({KIND_RELAX, 7'd0, 7'd1, 16'd0, 16'd0}, 1, {7'd0, 17'd0, 7'd0, 1'b0, 1'b1});
    add_row({KIND_RELAX, 7'd65, 7'd2, 16'd1, 16'd1}, 1, {7'd65, 17'd0, 7'd0, 1'b0, 1'b1});
    add_row({KIND_RELAX, 7'd127, 7'd3, 16'hFFFF, 16'hFFFF}, 1,
            {7'd127, 17'd0, 7'd0, 1'b0, 1'b1});
    // Own entry always reads zero and is never written
    add_row({KIND_RELAX, 7'd1, 7'd4, 16'd5, 16'd5}, 1, {7'd1, 17'd0, 7'd0, 1'b0, 1'b0});
    // Largest sum loses to infinity: entry stays unreachable
    add_row({KIND_RELAX, 7'd2, 7'd3, 16'hFFFF, 16'hFFFF}, 1,
            {7'd2, 17'd100000, 7'd0, 1'b0, 1'b0});
    // Zero cost at the top slot, odd neighbour stored as given
    add_row({KIND_RELAX, 7'd64, 7'd127, 16'd0, 16'd0}, 1,
            {7'd64, 17'd0, 7'd127, 1'b1, 1'b0});
    // Tie keeps the first neighbour
    add_row({KIND_RELAX, 7'd64, 7'd5, 16'd0, 16'd0}, 1, {7'd64, 17'd0, 7'd127, 1'b0, 1'b0});
    // Neighbour zero accepted as a hop
    add_row({KIND_RELAX, 7'd3, 7'd0, 16'd65535, 16'd34464}, 1,
            {7'd3, 17'd99999, 7'd0, 1'b1, 1'b0});
    add_row({KIND_RELAX, 7'd3, 7'd9, 16'd50000, 16'd49999}, 1,
            {7'd3, 17'd99999, 7'd0, 1'b0, 1'b0});
    add_row({KIND_RELAX, 7'd3, 7'd10, 16'd40000, 16'd10000}, 0, '0);
    // Sum equal to infinity is not an improvement
    add_row({KIND_RELAX, 7'd4, 7'd2, 16'd50000, 16'd50000}, 1,
            {7'd4, 17'd100000, 7'd0, 1'b0, 1'b0});
    add_row({KIND_RELAX, 7'd4, 7'd2, 16'd50000, 16'd49999}, 0, '0);
    // Alternating bit patterns in neighbour ids and in the first two rows' costs
    add_row({KIND_RELAX, 7'd2, 7'd42, 16'h5555, 16'hAAAA}, 0, '0);
    add_row({KIND_RELAX, 7'd42, 7'd85, 16'hAAAA, 16'h5555}, 0, '0);
    add_row({KIND_RELAX, 7'd21, 7'd42, 16'd1, 16'd0}, 0, '0);
    add_row({KIND_CLEAR, 7'd0, 7'd0, 16'd0, 16'd0}, 1, {7'd0, 17'd0, 7'd0, 1'b0, 1'b0});
    // After a clear, old entries read as infinity again
    add_row({KIND_RELAX, 7'd64, 7'd1, 16'd1, 16'd1}, 0, '0);
    add_row({KIND_RELAX, 7'd3, 7'd6, 16'hFFFF, 16'hFFFF}, 1,
            {7'd3, 17'd100000, 7'd0, 1'b0, 1'b0});
    add_row({KIND_RELAX, 7'd63, 7'd64, 16'd7, 16'd8}, 0, '0);

    // Table settings per pass: extremes first, then random ones.
    // Infinity is not lowered with a clear, so valid entries above it survive.
    plan_self[0] = 7'd64;  plan_count[0] = 7'd64;  plan_inf[0] = 17'd131071;
    plan_self[1] = 7'd1;   plan_count[1] = 7'd1;   plan_inf[1] = 17'd1;
    plan_self[2] = 7'd33;  plan_count[2] = 7'd64;  plan_inf[2] = 17'd5000;
    plan_self[3] = 7'd0;   plan_count[3] = 7'd127; plan_inf[3] = 17'd100000;
    plan_self[4] = 7'd2;   plan_count[4] = 7'd2;   plan_inf[4] = 17'd17;
    for (int p = 5; p < PHASES; p++) begin
      plan_self[p]  = ROUTER_W'($urandom_range(1, 64));
      plan_count[p] = ROUTER_W'($urandom_range(1, 64));
      plan_inf[p]   = COST_W'($urandom_range(1, 131071));
    end

    // Hold reset, then release it at a falling edge, away from the rising edge
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) drive_item(dir_rows[r].beat, dir_rows[r].typed, dir_rows[r].want, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      // Reconfigure only with the pipe empty
      settle_idle();
      write_cfg(CFG_SELF_ROUTER, COST_W'(plan_self[p]));
      write_cfg(CFG_ROUTER_COUNT, COST_W'(plan_count[p]));
      write_cfg(CFG_INFINITY_COST, plan_inf[p]);
      cfg_we_i <= 1'b0;
      @(negedge clk_i);

      for (int n = 0; n < BEATS_PER_PASS; n++) begin
        beat      = in_t'({$urandom(), $urandom()});
        beat.kind = KIND_RELAX;
        span      = (cfg_count == 0) ? 1 : ((cfg_count > TABLE_DEPTH) ? TABLE_DEPTH : cfg_count);
        hi        = (span > 6) ? 6 : span;
        pick      = $urandom_range(0, 99);
        // Mostly valid offers hammering a few entries, so ties and improvements
        // pile up; a sprinkling of clears, own-entry and out-of-range beats
        if (pick < 4) beat.kind = KIND_CLEAR;
        else if (pick < 12) beat.destination = ROUTER_W'($urandom_range(0, 127));
        else if (pick < 20) beat.destination = cfg_self;
        else if (pick < 60) beat.destination = ROUTER_W'($urandom_range(1, hi));
        else beat.destination = ROUTER_W'($urandom_range(1, span));
        if ($urandom_range(0, 9) != 0) beat.neighbour_id = ROUTER_W'($urandom_range(1, 64));
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          beat.advertised_cost = ADV_W'($urandom_range(0, 400));
          beat.link_delay      = ADV_W'($urandom_range(0, 400));
        end else if (pick < 65) begin
          beat.advertised_cost = ADV_W'($urandom_range(20000, 65535));
          beat.link_delay      = ADV_W'($urandom_range(20000, 65535));
        end
        // Odd passes run back to back with no idle gaps
        drive_item(beat, 1'b0, '0, p[0]);
      end
    end

    settle_idle();
    if (expected_entries_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_entries_q.size());
      mismatch_count++;
    end

    $display("Sent %0d beats (%0d clears) over %0d table settings; %0d results checked.",
             beats_sent, clears_sent, PHASES + 1, results_seen);
    $display("Results showed %0d route improvements and %0d out-of-range destinations.",
             improvements_seen, bad_dest_seen);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
